[rtl/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants of the TLS SNI extractor
// Parse phases, result record and protocol constants of the ClientHello walk.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int POS_W           = 17;
    localparam int CMP_W           = 18;
    localparam int IN_DATA_W       = 24;
    localparam int OUT_DATA_W      = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [16:0] SID_OFFSET      = 17'd43;
    localparam logic [16:0] HELLO_TYPE_POS  = 17'd5;
    localparam int          MIN_HELLO_LEN   = 40;
    localparam int          MIN_SID_LEN     = 45;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_HOST       = 8'h00;
    localparam logic [16:0] POS_MAX         = 17'h1FFFF;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        PH_SID,
        PH_CS,
        PH_CM,
        PH_EL,
        PH_EXH,
        PH_LIST,
        PH_NTYPE,
        PH_NLEN,
        PH_NAME,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic        client_hello;
        logic        sni_found;
        logic [15:0] host_len;
        logic        last;
    } t_result;

endpackage

[rtl/tls_sni_extractor.sv]
// ----------------------------------------------------------------------------
// tls_sni_extractor: server name extraction from a TLS ClientHello
// Walks a TCP payload byte by byte and streams out the SNI host name.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one payload byte per request: tdata holds the byte
//   and the payload length, tlast marks the last byte of the packet.
//   Master channel returns host name bytes (tuser = 0) as they pass, and one
//   summary (tuser = 1, tlast = 1) per packet carrying the ClientHello flag,
//   the found flag and the host name length.
//   A result is registered into the result queue as its byte is accepted.
//   Throughput: one byte per cycle while tready is high; one pass of parse
//   logic per byte updates the parser state. Results go through a 4-entry
//   result queue, so the input keeps flowing while the receiver holds a result;
//   tready drops only while more than two results are pending. The last name byte landing
//   on the packet's final byte yields two results in one cycle; the queue
//   absorbs them without stalling the input while the receiver keeps up.
//   When the receiver stalls, the queue fills and input tready falls; no
//   result is dropped.
//   Reset clears the parser state and the queue; both channels are idle
//   while reset is held.
// ----------------------------------------------------------------------------
module tls_sni_extractor
    import tse_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [7:0] payload_byte, [23:8] payload_length
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] name_byte, [8] client_hello, [9] sni_found,
    // [25:10] host_name_length, [31:26] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [0] result_kind
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    // parser state
    logic [POS_W-1:0]       r_pos, n_pos;
    t_phase                 r_phase, n_phase;
    logic [15:0]            r_acc, n_acc;
    logic [POS_W-1:0]       r_skip, n_skip;
    logic [POS_W-1:0]       r_limit, n_limit;
    logic [15:0]            r_left, n_left;
    logic [1:0]             r_marks, n_marks;
    logic [POS_W-1:0]       r_found, n_found;
    logic [LENGTH_BITS-1:0] r_pkt_len, n_pkt_len;
    logic [31:0]            r_hdr, n_hdr;
    logic [2:0]             r_cnt, n_cnt;
    logic [POS_W-1:0]       r_ext_next, n_ext_next;

    // result queue
    t_result                r_q [QUEUE_DEPTH];
    logic [QW-1:0]          r_wptr, r_rptr;
    logic [QW:0]            r_count;

    logic                   accept, pop;
    logic [7:0]             b;
    logic [POS_W-1:0]       p;
    logic [CMP_W-1:0]       p_len_x, lim_x;
    logic                   col_hit, col_done;
    logic [15:0]            col_acc;
    logic                   sh_go;
    logic [POS_W-1:0]       sh_start;
    logic [POS_W-1:0]       skip_inc, ext_sum;
    logic [31:0]            hdr_new;
    logic [1:0]             replay_d;
    logic                   name_v, sum_v;
    t_result                name_r, sum_r;

    assign accept = i_s_tvalid && o_s_tready;
    assign pop    = o_m_tvalid && i_m_tready;
    assign b      = i_s_tdata[7:0];
    assign p      = r_pos;

    assign o_s_tready = i_rst_n && (r_count <= (QW+1)'(QUEUE_DEPTH - 2));
    assign o_m_tvalid = i_rst_n && (r_count != '0);
    assign o_m_tdata  = {6'b0, r_q[r_rptr].host_len, r_q[r_rptr].sni_found,
                         r_q[r_rptr].client_hello, r_q[r_rptr].name_byte};
    assign o_m_tuser  = r_q[r_rptr].kind;
    assign o_m_tlast  = r_q[r_rptr].last;

    assign col_hit  = (p == r_skip);
    assign col_done = (r_cnt != 3'd0);
    assign col_acc  = {r_acc[7:0], b};
    assign skip_inc = r_skip + POS_W'(1);
    assign hdr_new  = {r_hdr[23:0], b};
    assign ext_sum  = skip_inc + POS_W'(hdr_new[15:0]);
    assign replay_d = 2'(p - r_ext_next);

    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_skip     = r_skip;
        n_limit    = r_limit;
        n_left     = r_left;
        n_marks    = r_marks;
        n_found    = r_found;
        n_pkt_len  = r_pkt_len;
        n_hdr      = r_hdr;
        n_cnt      = r_cnt;
        n_ext_next = r_ext_next;
        sh_go      = 1'b0;
        sh_start   = '0;
        name_v     = 1'b0;
        sum_v      = 1'b0;
        name_r     = '0;
        sum_r      = '0;
        p_len_x    = '0;
        lim_x      = '0;

        if (accept) begin
            if (p == '0) begin
                n_pkt_len = i_s_tdata[8 +: LENGTH_BITS];
                if (b == REC_HANDSHAKE) n_marks[0] = 1'b1;
            end
            if (p == HELLO_TYPE_POS && b == HS_CLIENT_HELLO) n_marks[1] = 1'b1;
            p_len_x = CMP_W'(n_pkt_len);

            case (r_phase)
                PH_SID: begin
                    if (p == SID_OFFSET) begin
                        if (p_len_x < CMP_W'(MIN_SID_LEN)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_skip  = POS_W'(44) + POS_W'(b);
                            n_cnt   = '0;
                            n_acc   = '0;
                            n_phase = (CMP_W'(n_skip) + CMP_W'(2) <= p_len_x) ? PH_CS
                                                                               : PH_DONE;
                        end
                    end
                end
                PH_CS: begin
                    if (col_hit) begin
                        n_acc  = col_acc;
                        n_skip = skip_inc;
                        n_cnt  = col_done ? 3'd0 : r_cnt + 3'd1;
                        if (col_done) begin
                            n_skip  = skip_inc + POS_W'(col_acc);
                            n_phase = (CMP_W'(n_skip) + CMP_W'(1) <= p_len_x) ? PH_CM
                                                                               : PH_DONE;
                        end
                    end
                end
                PH_CM: begin
                    if (col_hit) begin
                        n_skip  = skip_inc + POS_W'(b);
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_phase = (CMP_W'(n_skip) + CMP_W'(2) <= p_len_x) ? PH_EL : PH_DONE;
                    end
                end
                PH_EL: begin
                    if (col_hit) begin
                        n_acc  = col_acc;
                        n_skip = skip_inc;
                        n_cnt  = col_done ? 3'd0 : r_cnt + 3'd1;
                        if (col_done) begin
                            lim_x    = CMP_W'(skip_inc) + CMP_W'(col_acc);
                            n_limit  = (lim_x > p_len_x) ? POS_W'(n_pkt_len) : POS_W'(lim_x);
                            sh_go    = 1'b1;
                            sh_start = skip_inc;
                        end
                    end
                end
                PH_EXH: begin
                    if (col_hit) begin
                        n_hdr  = hdr_new;
                        n_skip = skip_inc;
                        n_cnt  = r_cnt + 3'd1;
                        if (r_cnt == 3'd3) begin
                            n_ext_next = ext_sum;
                            n_cnt      = '0;
                            n_acc      = '0;
                            if (hdr_new[31:16] != EXT_SERVER_NAME) begin
                                sh_go    = 1'b1;
                                sh_start = ext_sum;
                            end else if (CMP_W'(skip_inc) + CMP_W'(5) > CMP_W'(r_limit)) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_LIST;
                            end
                        end
                    end
                end
                PH_LIST: begin
                    if (col_hit) begin
                        n_acc  = col_acc;
                        n_skip = skip_inc;
                        n_cnt  = col_done ? 3'd0 : r_cnt + 3'd1;
                        if (col_done) begin
                            n_phase = (CMP_W'(skip_inc) + CMP_W'(col_acc) > CMP_W'(r_limit))
                                      ? PH_DONE : PH_NTYPE;
                        end
                    end
                end
                PH_NTYPE: begin
                    if (col_hit) begin
                        n_skip = skip_inc;
                        if (b == NAME_HOST) begin
                            n_cnt   = '0;
                            n_acc   = '0;
                            n_phase = PH_NLEN;
                        end else if (r_ext_next > p) begin
                            sh_go    = 1'b1;
                            sh_start = r_ext_next;
                        end else if (CMP_W'(r_ext_next) + CMP_W'(4) > CMP_W'(r_limit)) begin
                            n_phase = PH_DONE;
                        end else begin
                            // next header overlaps the list length: rebuild it
                            case (replay_d)
                                2'd0:    n_hdr = {24'b0, b};
                                2'd1:    n_hdr = {16'b0, r_acc[7:0], b};
                                default: n_hdr = {8'b0, r_acc, b};
                            endcase
                            n_cnt   = 3'(replay_d) + 3'd1;
                            n_phase = PH_EXH;
                        end
                    end
                end
                PH_NLEN: begin
                    if (col_hit) begin
                        n_acc  = col_acc;
                        n_skip = skip_inc;
                        n_cnt  = col_done ? 3'd0 : r_cnt + 3'd1;
                        if (col_done) begin
                            if (CMP_W'(skip_inc) + CMP_W'(col_acc) > CMP_W'(r_limit)
                                || col_acc == 16'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_left  = col_acc;
                                n_phase = PH_NAME;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    if (col_hit) begin
                        name_v           = 1'b1;
                        name_r.kind      = KIND_NAME;
                        name_r.name_byte = b;
                        n_skip           = skip_inc;
                        n_left           = r_left - 16'd1;
                        if (r_left == 16'd1) begin
                            n_found = {1'b1, r_acc};
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase

            if (sh_go) begin
                if (CMP_W'(sh_start) + CMP_W'(4) > CMP_W'(n_limit)) begin
                    n_phase = PH_DONE;
                end else begin
                    n_skip  = sh_start;
                    n_cnt   = '0;
                    n_hdr   = '0;
                    n_phase = PH_EXH;
                end
            end

            if (r_pos != POS_MAX) n_pos = r_pos + POS_W'(1);

            if (i_s_tlast) begin
                sum_v              = 1'b1;
                sum_r.kind         = KIND_SUMMARY;
                sum_r.client_hello = (p_len_x >= CMP_W'(MIN_HELLO_LEN)) && (n_marks == 2'b11);
                sum_r.sni_found    = n_found[16];
                sum_r.host_len     = n_found[15:0];
                sum_r.last         = 1'b1;
                // packet done: return to the idle parser state
                n_pos      = '0;
                n_phase    = PH_SID;
                n_acc      = '0;
                n_skip     = '0;
                n_limit    = '0;
                n_left     = '0;
                n_marks    = '0;
                n_found    = '0;
                n_pkt_len  = '0;
                n_hdr      = '0;
                n_cnt      = '0;
                n_ext_next = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= PH_SID;
            r_acc      <= '0;
            r_skip     <= '0;
            r_limit    <= '0;
            r_left     <= '0;
            r_marks    <= '0;
            r_found    <= '0;
            r_pkt_len  <= '0;
            r_hdr      <= '0;
            r_cnt      <= '0;
            r_ext_next <= '0;
        end else begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_skip     <= n_skip;
            r_limit    <= n_limit;
            r_left     <= n_left;
            r_marks    <= n_marks;
            r_found    <= n_found;
            r_pkt_len  <= n_pkt_len;
            r_hdr      <= n_hdr;
            r_cnt      <= n_cnt;
            r_ext_next <= n_ext_next;
        end
    end

    // result queue: name byte first, then summary
    always_ff @(posedge i_clk) begin
        if (name_v) begin
            r_q[r_wptr] <= name_r;
        end
        if (sum_v) begin
            r_q[name_v ? r_wptr + QW'(1) : r_wptr] <= sum_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QW'(name_v) + QW'(sum_v);
            r_rptr  <= r_rptr + QW'(pop);
            r_count <= r_count + (QW+1)'(name_v) + (QW+1)'(sum_v) - (QW+1)'(pop);
        end
    end

endmodule

[rtl/tse_checker.sv]
// ----------------------------------------------------------------------------
// tse_checker: port-level checks of the TLS SNI extractor
// Watches both channels for reset behavior and the result channel for holding and field coding.
// ----------------------------------------------------------------------------
module tse_checker
    import tse_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser,
    input logic                  o_m_tlast
);

    // stalled result holds its data and kind
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |-> !o_m_tvalid && !o_s_tready)
        else $error("channel active during reset");

    // only the summary closes a packet
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == o_m_tlast))
        else $error("tlast does not match summary kind");

    a_name_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_NAME) |-> (o_m_tdata[31:8] == '0))
        else $error("name byte carries summary fields");

    a_len_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_SUMMARY)
        |-> (o_m_tdata[9] == (o_m_tdata[25:10] != 16'd0)) && (o_m_tdata[7:0] == 8'd0))
        else $error("summary length and found flag disagree");

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (.*);
